### rtl/tlic_pkg.sv
// Shared types, constants and helpers for the two-level inclusive cache tag model.
// No dependencies; the top level, tlic_front and tlic_back refer to this package by scoped names.
package tlic_pkg;

  localparam int L1_SETS_DEF   = 64;
  localparam int L1_WAYS_DEF   = 4;
  localparam int L2_SETS_DEF   = 256;
  localparam int L2_WAYS_DEF   = 8;
  localparam int ADDR_BITS_DEF = 32;

  localparam int TAG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS   = 3'd0,
    CFG_L1_INDEX_BITS = 3'd1,
    CFG_L2_INDEX_BITS = 3'd2,
    CFG_L1_WAYS       = 3'd3,
    CFG_L2_WAYS       = 3'd4,
    CFG_RANDOM_MODE   = 3'd5,
    CFG_RANDOM_SEED   = 3'd6
  } cfg_idx_t;

  localparam logic [3:0]  OFFSET_RST   = 4'd6;
  localparam logic [2:0]  L1_INDEX_RST = 3'd4;
  localparam logic [3:0]  L2_INDEX_RST = 4'd6;
  localparam logic [2:0]  L1_WAYS_RST  = 3'd2;
  localparam logic [3:0]  L2_WAYS_RST  = 4'd8;
  localparam logic        RND_MODE_RST = 1'b0;
  localparam logic [15:0] SEED_RST     = 16'd44257;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic        l1_hit;
    logic        l2_hit;
    logic        l2_victim_valid;
    logic        l2_victim_dirty;
    logic [31:0] l2_victim_address;
    logic        back_invalidated;
    logic        l1_victim_valid;
    logic        l1_victim_dirty;
    logic [31:0] l1_victim_address;
    logic        writeback_marked;
  } out_item_t;

  // Configuration after range fitting.
  typedef struct packed {
    logic [3:0] off;
    logic [3:0] ib1;
    logic [3:0] ib2;
    logic [5:0] w1;
    logic [5:0] w2;
    logic       rnd;
  } cfg_eff_t;

  // Right-shifting Fibonacci LFSR, taps 16,14,13,11.
  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    logic b;
    b = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {b, s[15:1]};
  endfunction

endpackage

### rtl/two_level_inclusive_cache_model.sv
// Top level of the two-level inclusive cache tag model: configuration registers,
// front end queue and back end sequencer. Depends on tlic_pkg, tlic_front, tlic_back.
//
//  channel   dir  handshake            payload
//  in        in   in_valid/in_ready    in_data   (action, address)
//  out       out  out_valid/out_ready  out_data  (hit flags, victims, write-back mark)
//  cfg       in   cfg_we               cfg_index, cfg_data
//
// An L1 hit takes a row read, then an update, in the back end. An L1 miss takes
// the L2 lookup, an optional L2 fill with back-invalidation read of the
// victim's L1 row, the L1 fill, and an optional L2 read to mark a dirty L1 victim.
// Each random victim draw adds a pass through the remainder unit. The dependent row
// reads of both levels, one registered read per memory a cycle, set this sequence.
// A 2-entry queue takes accesses meanwhile.
// After reset the block sweeps both row memories, one row a cycle, clearing
// every row of both, with in_ready low.
// The next access starts once the previous transfer on out has completed.
module two_level_inclusive_cache_model #(
  parameter int L1_SETS   = tlic_pkg::L1_SETS_DEF,
  parameter int L1_WAYS   = tlic_pkg::L1_WAYS_DEF,
  parameter int L2_SETS   = tlic_pkg::L2_SETS_DEF,
  parameter int L2_WAYS   = tlic_pkg::L2_WAYS_DEF,
  parameter int ADDR_BITS = tlic_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tlic_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tlic_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [tlic_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlic_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Largest index width whose set count still fits each level.
  localparam int L1_IB_MAX = $clog2(L1_SETS + 1) - 1;
  localparam int L2_IB_MAX = $clog2(L2_SETS + 1) - 1;
  localparam int S1W = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
  localparam int S2W = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;

  logic [3:0]  offset_bits;
  logic [2:0]  l1_index_bits;
  logic [3:0]  l2_index_bits;
  logic [2:0]  l1_ways_used;
  logic [3:0]  l2_ways_used;
  logic        random_mode;

  tlic_pkg::cfg_eff_t cfg;
  logic               seed_load;
  logic [15:0]        seed_value;
  logic               clearing;
  logic               pop;
  logic               head_valid;
  logic               head_wr;
  logic [31:0]        head_t1;
  logic [31:0]        head_t2;
  logic [S1W-1:0]     head_s1;
  logic [S2W-1:0]     head_s2;

  // Configuration writes; the seed register lives as the LFSR in the back end.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits   <= tlic_pkg::OFFSET_RST;
      l1_index_bits <= tlic_pkg::L1_INDEX_RST;
      l2_index_bits <= tlic_pkg::L2_INDEX_RST;
      l1_ways_used  <= tlic_pkg::L1_WAYS_RST;
      l2_ways_used  <= tlic_pkg::L2_WAYS_RST;
      random_mode   <= tlic_pkg::RND_MODE_RST;
    end else if (cfg_we) begin
      case (tlic_pkg::cfg_idx_t'(cfg_index))
        tlic_pkg::CFG_OFFSET_BITS:   offset_bits   <= cfg_data[3:0];
        tlic_pkg::CFG_L1_INDEX_BITS: l1_index_bits <= cfg_data[2:0];
        tlic_pkg::CFG_L2_INDEX_BITS: l2_index_bits <= cfg_data[3:0];
        tlic_pkg::CFG_L1_WAYS:       l1_ways_used  <= cfg_data[2:0];
        tlic_pkg::CFG_L2_WAYS:       l2_ways_used  <= cfg_data[3:0];
        tlic_pkg::CFG_RANDOM_MODE:   random_mode   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // A zero seed loads one so the LFSR never locks up.
  assign seed_load  = cfg_we && (tlic_pkg::cfg_idx_t'(cfg_index) == tlic_pkg::CFG_RANDOM_SEED);
  assign seed_value = (cfg_data == '0) ? 16'd1 : cfg_data;

  // Fit index widths to the set counts and ways to the built associativity.
  always_comb begin
    cfg.off = offset_bits;
    cfg.ib1 = (int'(l1_index_bits) > L1_IB_MAX) ? 4'(L1_IB_MAX) : {1'b0, l1_index_bits};
    cfg.ib2 = (int'(l2_index_bits) > L2_IB_MAX) ? 4'(L2_IB_MAX) : l2_index_bits;
    if (l1_ways_used == '0) begin
      cfg.w1 = 6'd1;
    end else if (int'(l1_ways_used) > L1_WAYS) begin
      cfg.w1 = 6'(L1_WAYS);
    end else begin
      cfg.w1 = {3'd0, l1_ways_used};
    end
    if (l2_ways_used == '0) begin
      cfg.w2 = 6'd1;
    end else if (int'(l2_ways_used) > L2_WAYS) begin
      cfg.w2 = 6'(L2_WAYS);
    end else begin
      cfg.w2 = {2'd0, l2_ways_used};
    end
    cfg.rnd = random_mode;
  end

  tlic_front #(
    .L1_SETS(L1_SETS), .L2_SETS(L2_SETS), .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk(clk), .rst(rst), .clearing(clearing), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .pop(pop), .head_valid(head_valid), .head_wr(head_wr),
    .head_t1(head_t1), .head_t2(head_t2), .head_s1(head_s1), .head_s2(head_s2)
  );

  tlic_back #(
    .L1_SETS(L1_SETS), .L1_WAYS(L1_WAYS), .L2_SETS(L2_SETS), .L2_WAYS(L2_WAYS),
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .seed_load(seed_load), .seed_value(seed_value),
    .clearing(clearing), .head_valid(head_valid), .head_wr(head_wr),
    .head_t1(head_t1), .head_t2(head_t2), .head_s1(head_s1), .head_s2(head_s2),
    .pop(pop), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

### rtl/tlic_store.sv
// One row-wide tag/state memory: a row holds every way of one set.
// Generic; one write port, one read port with registered read data.
module tlic_store #(
  parameter int SETS = 64,
  parameter int RW   = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] waddr,
  input  logic [RW-1:0]                        wdata,
  input  logic                                 re,
  input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] raddr,
  output logic [RW-1:0]                        rdata
);

  logic [RW-1:0] mem [SETS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tlic_rowop.sv
// Per-row cache logic: tag lookup, victim choice and LRU age update for one set.
// Uses nothing from the package; purely combinational.
module tlic_rowop #(
  parameter int WAYS = 4
) (
  input  logic [WAYS-1:0][31:0]                            tag,
  input  logic [WAYS-1:0]                                  vld,
  input  logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] age,
  input  logic [5:0]                                       ways,
  input  logic [31:0]                                      find_tag,
  input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]       touch_way,
  output logic                                             hit,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]       hit_way,
  output logic                                             free,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]       free_way,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]       lru_way,
  output logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] age_touched
);

  localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic          a_vld;
  logic [AW-1:0] a_age;

  // Lowest matching / lowest free way: scan downward so the lowest wins.
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (w < int'(ways)) begin
        if (vld[w] && (tag[w] == find_tag)) begin
          hit     = 1'b1;
          hit_way = AW'(w);
        end
        if (!vld[w]) begin
          free     = 1'b1;
          free_way = AW'(w);
        end
      end
    end
  end

  // Oldest way, lowest on a tie.
  always_comb begin
    lru_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if ((w < int'(ways)) && (age[w] > age[lru_way])) begin
        lru_way = AW'(w);
      end
    end
  end

  // Age every valid way younger than the touched one; an invalid touched way
  // counts as older than all.
  assign a_vld = vld[touch_way];
  assign a_age = age[touch_way];

  always_comb begin
    age_touched = age;
    for (int w = 0; w < WAYS; w++) begin
      if ((AW'(w) != touch_way) && (w < int'(ways)) && vld[w] &&
          (!a_vld || (age[w] < a_age)) && (int'(age[w]) + 1 < WAYS)) begin
        age_touched[w] = age[w] + AW'(1);
      end
    end
    age_touched[touch_way] = '0;
  end

endmodule

### rtl/tlic_front.sv
// Front end: accepts accesses, splits the address into sets and tags for both
// levels, and holds them in a short queue. Depends on tlic_pkg.
module tlic_front #(
  parameter int L1_SETS   = tlic_pkg::L1_SETS_DEF,
  parameter int L2_SETS   = tlic_pkg::L2_SETS_DEF,
  parameter int ADDR_BITS = tlic_pkg::ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clearing,
  input  tlic_pkg::cfg_eff_t         cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tlic_pkg::in_item_t         in_data,
  input  logic                       pop,
  output logic                       head_valid,
  output logic                       head_wr,
  output logic [31:0]                head_t1,
  output logic [31:0]                head_t2,
  output logic [((L1_SETS > 1) ? $clog2(L1_SETS) : 1)-1:0] head_s1,
  output logic [((L2_SETS > 1) ? $clog2(L2_SETS) : 1)-1:0] head_s2
);

  localparam int S1W = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
  localparam int S2W = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
  localparam int PW  = (tlic_pkg::Q_DEPTH > 1) ? $clog2(tlic_pkg::Q_DEPTH) : 1;
  localparam int CW  = $clog2(tlic_pkg::Q_DEPTH + 1);
  localparam logic [31:0] ADDR_MASK32 =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

  logic           q_wr [tlic_pkg::Q_DEPTH];
  logic [31:0]    q_t1 [tlic_pkg::Q_DEPTH];
  logic [31:0]    q_t2 [tlic_pkg::Q_DEPTH];
  logic [S1W-1:0] q_s1 [tlic_pkg::Q_DEPTH];
  logic [S2W-1:0] q_s2 [tlic_pkg::Q_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  logic        push;
  logic [31:0] addr;
  logic [31:0] blk;
  logic [4:0]  sh1;
  logic [4:0]  sh2;

  assign in_ready   = !clearing && (count != CW'(tlic_pkg::Q_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (count != '0);

  // Decode the access against the current configuration.
  assign addr = in_data.address & ADDR_MASK32;
  assign blk  = addr >> cfg.off;
  assign sh1  = {1'b0, cfg.off} + {1'b0, cfg.ib1};
  assign sh2  = {1'b0, cfg.off} + {1'b0, cfg.ib2};

  always_ff @(posedge clk) begin
    if (push) begin
      q_wr[wr_ptr] <= in_data.action;
      q_t1[wr_ptr] <= addr >> sh1;
      q_t2[wr_ptr] <= addr >> sh2;
      q_s1[wr_ptr] <= S1W'(blk & ((32'd1 << cfg.ib1) - 32'd1));
      q_s2[wr_ptr] <= S2W'(blk & ((32'd1 << cfg.ib2) - 32'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(tlic_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(tlic_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign head_wr = q_wr[rd_ptr];
  assign head_t1 = q_t1[rd_ptr];
  assign head_t2 = q_t2[rd_ptr];
  assign head_s1 = q_s1[rd_ptr];
  assign head_s2 = q_s2[rd_ptr];

endmodule

### rtl/tlic_back.sv
// Back end: sequencer that walks one access through the L1 and L2 row memories,
// back-invalidation, victim choice and write-back marking. Depends on tlic_pkg,
// tlic_store and tlic_rowop.
module tlic_back #(
  parameter int L1_SETS   = tlic_pkg::L1_SETS_DEF,
  parameter int L1_WAYS   = tlic_pkg::L1_WAYS_DEF,
  parameter int L2_SETS   = tlic_pkg::L2_SETS_DEF,
  parameter int L2_WAYS   = tlic_pkg::L2_WAYS_DEF,
  parameter int ADDR_BITS = tlic_pkg::ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tlic_pkg::cfg_eff_t         cfg,
  input  logic                       seed_load,
  input  logic [15:0]                seed_value,
  output logic                       clearing,
  input  logic                       head_valid,
  input  logic                       head_wr,
  input  logic [31:0]                head_t1,
  input  logic [31:0]                head_t2,
  input  logic [((L1_SETS > 1) ? $clog2(L1_SETS) : 1)-1:0] head_s1,
  input  logic [((L2_SETS > 1) ? $clog2(L2_SETS) : 1)-1:0] head_s2,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tlic_pkg::out_item_t        out_data
);

  localparam int S1W  = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
  localparam int S2W  = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
  localparam int A1W  = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int A2W  = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int MAXS = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
  localparam int CLW  = (MAXS > 1) ? $clog2(MAXS) : 1;
  localparam logic [63:0] ADDR_MASK64 =
    (ADDR_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << ADDR_BITS) - 64'd1);

  typedef struct packed {
    logic [L1_WAYS-1:0][31:0]    tag;
    logic [L1_WAYS-1:0]          vld;
    logic [L1_WAYS-1:0]          drt;
    logic [L1_WAYS-1:0][A1W-1:0] age;
  } row1_t;

  typedef struct packed {
    logic [L2_WAYS-1:0][31:0]    tag;
    logic [L2_WAYS-1:0]          vld;
    logic [L2_WAYS-1:0]          drt;
    logic [L2_WAYS-1:0][A2W-1:0] age;
  } row2_t;

  typedef enum logic [9:0] {
    ST_CLEAR   = 10'b00_0000_0001,
    ST_IDLE    = 10'b00_0000_0010,
    ST_LOOK    = 10'b00_0000_0100,
    ST_RND2    = 10'b00_0000_1000,
    ST_MISS2   = 10'b00_0001_0000,
    ST_INVAL   = 10'b00_0010_0000,
    ST_CHOOSE1 = 10'b00_0100_0000,
    ST_RND1    = 10'b00_1000_0000,
    ST_FILL1   = 10'b01_0000_0000,
    ST_MARK    = 10'b10_0000_0000
  } state_t;

  function automatic logic [63:0] blk_addr(input logic [31:0] tag, input logic [15:0] set,
                                           input logic [3:0] off, input logic [3:0] ib);
    logic [4:0] sh;
    sh = {1'b0, off} + {1'b0, ib};
    return ((64'(tag) << sh) | (64'(set) << off)) & ADDR_MASK64;
  endfunction

  function automatic logic [15:0] set_of(input logic [63:0] va, input logic [3:0] off,
                                         input logic [3:0] ib);
    return 16'((va >> off) & ((64'd1 << ib) - 64'd1));
  endfunction

  function automatic logic [31:0] tag_of(input logic [63:0] va, input logic [3:0] off,
                                         input logic [3:0] ib);
    logic [4:0] sh;
    sh = {1'b0, off} + {1'b0, ib};
    return 32'(va >> sh);
  endfunction

  state_t state, state_next;
  logic [CLW-1:0] clr_cnt;
  logic [15:0]    lfsr;
  logic [15:0]    lfsr_adv;
  logic           lfsr_step;

  // Job registers.
  logic           wr_q;
  logic [31:0]    t1_q, t2_q;
  logic [S1W-1:0] s1_q;
  logic [S2W-1:0] s2_q;
  row1_t          row1_q;
  row2_t          row2_q;
  logic [A1W-1:0] v1_q;
  logic [A2W-1:0] v2_q;
  logic [S1W-1:0] vs_q;
  logic [31:0]    vt_q;
  logic [S2W-1:0] vs2_q;
  logic [31:0]    vt2_q;
  tlic_pkg::out_item_t res_q, res_next;
  logic           fin;

  // Remainder unit, eight bits a cycle.
  logic [15:0] mod_x_q;
  logic [5:0]  mod_r_q;
  logic        mod_half_q;
  logic [5:0]  mod_w;
  logic [5:0]  mod_acc;
  logic [6:0]  mod_t;
  logic [5:0]  mod_r_step;

  // Memory ports.
  logic           m1_we, m1_re, m2_we, m2_re;
  logic [S1W-1:0] m1_waddr, m1_raddr;
  logic [S2W-1:0] m2_waddr, m2_raddr;
  row1_t          m1_wdata, rd1;
  row2_t          m2_wdata, rd2;

  // Row operation results.
  logic                        h1a_hit, h1b_free, h2a_hit, h2a_free;
  logic [A1W-1:0]              h1a_way, h1b_free_way, h1b_lru;
  logic [A2W-1:0]              h2a_way, h2a_free_way, h2a_lru;
  logic [L1_WAYS-1:0][A1W-1:0] h1a_age, h1b_age;
  logic [L2_WAYS-1:0][A2W-1:0] h2a_age, h2b_age;
  logic [31:0]                 find1, find2;

  row1_t       look1_row, inv_row, fill1_row;
  row2_t       look2_row, fill2_row, mark_row;
  logic [63:0] va1, va2;

  tlic_store #(.SETS(L1_SETS), .RW($bits(row1_t))) u_l1 (
    .clk(clk), .we(m1_we), .waddr(m1_waddr), .wdata(m1_wdata),
    .re(m1_re), .raddr(m1_raddr), .rdata(rd1)
  );

  tlic_store #(.SETS(L2_SETS), .RW($bits(row2_t))) u_l2 (
    .clk(clk), .we(m2_we), .waddr(m2_waddr), .wdata(m2_wdata),
    .re(m2_re), .raddr(m2_raddr), .rdata(rd2)
  );

  assign find1 = (state == ST_INVAL) ? vt_q : t1_q;
  assign find2 = (state == ST_MARK) ? vt2_q : t2_q;

  // Lookup on freshly read L1 row: requested tag, or the L2 victim's tag.
  tlic_rowop #(.WAYS(L1_WAYS)) u_op1a (
    .tag(rd1.tag), .vld(rd1.vld), .age(rd1.age), .ways(cfg.w1),
    .find_tag(find1), .touch_way(h1a_way),
    .hit(h1a_hit), .hit_way(h1a_way), .free(), .free_way(),
    .lru_way(), .age_touched(h1a_age)
  );

  // Victim choice and fill on the held L1 row.
  tlic_rowop #(.WAYS(L1_WAYS)) u_op1b (
    .tag(row1_q.tag), .vld(row1_q.vld), .age(row1_q.age), .ways(cfg.w1),
    .find_tag(t1_q), .touch_way(v1_q),
    .hit(), .hit_way(), .free(h1b_free), .free_way(h1b_free_way),
    .lru_way(h1b_lru), .age_touched(h1b_age)
  );

  // Lookup on freshly read L2 row: requested tag, or the L1 victim's tag.
  tlic_rowop #(.WAYS(L2_WAYS)) u_op2a (
    .tag(rd2.tag), .vld(rd2.vld), .age(rd2.age), .ways(cfg.w2),
    .find_tag(find2), .touch_way(h2a_way),
    .hit(h2a_hit), .hit_way(h2a_way), .free(h2a_free), .free_way(h2a_free_way),
    .lru_way(h2a_lru), .age_touched(h2a_age)
  );

  // Fill on the held L2 row.
  tlic_rowop #(.WAYS(L2_WAYS)) u_op2b (
    .tag(row2_q.tag), .vld(row2_q.vld), .age(row2_q.age), .ways(cfg.w2),
    .find_tag(t2_q), .touch_way(v2_q),
    .hit(), .hit_way(), .free(), .free_way(),
    .lru_way(), .age_touched(h2b_age)
  );

  assign va2 = blk_addr(row2_q.tag[v2_q], 16'(s2_q), cfg.off, cfg.ib2);
  assign va1 = blk_addr(row1_q.tag[v1_q], 16'(s1_q), cfg.off, cfg.ib1);

  always_comb begin
    look1_row = rd1;
    look1_row.age = h1a_age;
    if (wr_q) begin
      look1_row.drt[h1a_way] = 1'b1;
    end
    inv_row = rd1;
    inv_row.vld[h1a_way] = 1'b0;
    inv_row.drt[h1a_way] = 1'b0;
    fill1_row = row1_q;
    fill1_row.age = h1b_age;
    fill1_row.tag[v1_q] = t1_q;
    fill1_row.vld[v1_q] = 1'b1;
    fill1_row.drt[v1_q] = wr_q;
    look2_row = rd2;
    look2_row.age = h2a_age;
    fill2_row = row2_q;
    fill2_row.age = h2b_age;
    fill2_row.tag[v2_q] = t2_q;
    fill2_row.vld[v2_q] = 1'b1;
    fill2_row.drt[v2_q] = 1'b0;
    mark_row = rd2;
    mark_row.drt[h2a_way] = 1'b1;
  end

  // Remainder of the drawn value by the ways in use, shift-and-subtract.
  assign mod_w = (state == ST_RND2) ? cfg.w2 : cfg.w1;

  always_comb begin
    mod_acc = mod_r_q;
    mod_t   = '0;
    for (int i = 0; i < 8; i++) begin
      mod_t = {mod_acc, mod_x_q[15-i]};
      if (mod_t >= {1'b0, mod_w}) begin
        mod_t = mod_t - {1'b0, mod_w};
      end
      mod_acc = mod_t[5:0];
    end
    mod_r_step = mod_acc;
  end

  assign lfsr_adv = tlic_pkg::lfsr_next(lfsr);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    fin        = 1'b0;
    lfsr_step  = 1'b0;
    res_next   = res_q;
    m1_we      = 1'b0;
    m1_waddr   = s1_q;
    m1_wdata   = fill1_row;
    m1_re      = 1'b0;
    m1_raddr   = s1_q;
    m2_we      = 1'b0;
    m2_waddr   = s2_q;
    m2_wdata   = fill2_row;
    m2_re      = 1'b0;
    m2_raddr   = s2_q;
    case (state)
      ST_CLEAR: begin
        m1_we    = (int'(clr_cnt) < L1_SETS);
        m1_waddr = clr_cnt[S1W-1:0];
        m1_wdata = '0;
        m2_we    = (int'(clr_cnt) < L2_SETS);
        m2_waddr = clr_cnt[S2W-1:0];
        m2_wdata = '0;
        if (clr_cnt == CLW'(MAXS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid && !out_valid) begin
          pop        = 1'b1;
          res_next   = '0;
          m1_re      = 1'b1;
          m1_raddr   = head_s1;
          m2_re      = 1'b1;
          m2_raddr   = head_s2;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (h1a_hit) begin
          m1_we           = 1'b1;
          m1_wdata        = look1_row;
          res_next.l1_hit = 1'b1;
          fin             = 1'b1;
          state_next      = ST_IDLE;
        end else if (h2a_hit) begin
          m2_we           = 1'b1;
          m2_wdata        = look2_row;
          res_next.l2_hit = 1'b1;
          state_next      = ST_CHOOSE1;
        end else if (h2a_free || !cfg.rnd) begin
          state_next = ST_MISS2;
        end else begin
          lfsr_step  = 1'b1;
          state_next = ST_RND2;
        end
      end
      ST_RND2: begin
        if (mod_half_q) begin
          state_next = ST_MISS2;
        end
      end
      ST_MISS2: begin
        m2_we = 1'b1;
        if (row2_q.vld[v2_q]) begin
          res_next.l2_victim_valid   = 1'b1;
          res_next.l2_victim_dirty   = row2_q.drt[v2_q];
          res_next.l2_victim_address = va2[31:0];
          m1_re      = 1'b1;
          m1_raddr   = S1W'(set_of(va2, cfg.off, cfg.ib1));
          state_next = ST_INVAL;
        end else begin
          state_next = ST_CHOOSE1;
        end
      end
      ST_INVAL: begin
        if (h1a_hit) begin
          m1_we    = 1'b1;
          m1_waddr = vs_q;
          m1_wdata = inv_row;
          res_next.back_invalidated = 1'b1;
          if (rd1.drt[h1a_way]) begin
            res_next.l2_victim_dirty = 1'b1;
          end
        end
        state_next = ST_CHOOSE1;
      end
      ST_CHOOSE1: begin
        if (h1b_free || !cfg.rnd) begin
          state_next = ST_FILL1;
        end else begin
          lfsr_step  = 1'b1;
          state_next = ST_RND1;
        end
      end
      ST_RND1: begin
        if (mod_half_q) begin
          state_next = ST_FILL1;
        end
      end
      ST_FILL1: begin
        m1_we = 1'b1;
        if (row1_q.vld[v1_q]) begin
          res_next.l1_victim_valid   = 1'b1;
          res_next.l1_victim_dirty   = row1_q.drt[v1_q];
          res_next.l1_victim_address = va1[31:0];
        end
        if (row1_q.vld[v1_q] && row1_q.drt[v1_q]) begin
          m2_re      = 1'b1;
          m2_raddr   = S2W'(set_of(va1, cfg.off, cfg.ib2));
          state_next = ST_MARK;
        end else begin
          fin        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MARK: begin
        if (h2a_hit) begin
          m2_we    = 1'b1;
          m2_waddr = vs2_q;
          m2_wdata = mark_row;
          res_next.writeback_marked = 1'b1;
        end
        fin        = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign clearing = (state == ST_CLEAR);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      lfsr      <= tlic_pkg::SEED_RST;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLW'(1);
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (seed_load) begin
        lfsr <= seed_value;
      end else if (lfsr_step) begin
        lfsr <= lfsr_adv;
      end
    end
  end

  // Payload: job, held rows, victims, remainder unit, result.
  always_ff @(posedge clk) begin
    res_q <= res_next;
    if (fin) begin
      out_data <= res_next;
    end
    if (pop) begin
      wr_q <= head_wr;
      t1_q <= head_t1;
      t2_q <= head_t2;
      s1_q <= head_s1;
      s2_q <= head_s2;
    end
    if (lfsr_step) begin
      mod_x_q    <= lfsr_adv;
      mod_r_q    <= '0;
      mod_half_q <= 1'b0;
    end else begin
      mod_x_q    <= {mod_x_q[7:0], 8'd0};
      mod_r_q    <= mod_r_step;
      mod_half_q <= 1'b1;
    end
    case (state)
      ST_LOOK: begin
        row1_q <= rd1;
        row2_q <= rd2;
        v2_q   <= h2a_free ? h2a_free_way : h2a_lru;
      end
      ST_RND2: begin
        v2_q <= A2W'(mod_r_step);
      end
      ST_MISS2: begin
        vs_q <= S1W'(set_of(va2, cfg.off, cfg.ib1));
        vt_q <= tag_of(va2, cfg.off, cfg.ib1);
      end
      ST_INVAL: begin
        if (h1a_hit && (vs_q == s1_q)) begin
          row1_q <= inv_row;
        end
      end
      ST_CHOOSE1: begin
        v1_q <= h1b_free ? h1b_free_way : h1b_lru;
      end
      ST_RND1: begin
        v1_q <= A1W'(mod_r_step);
      end
      ST_FILL1: begin
        vs2_q <= S2W'(set_of(va1, cfg.off, cfg.ib2));
        vt2_q <= tag_of(va1, cfg.off, cfg.ib2);
      end
      default: begin
      end
    endcase
  end

endmodule
